// ===== hdl/bbdc_pkg.sv =====
`default_nettype none
package bbdc_pkg;

  localparam int unsigned MaxEntries = 4096;
  localparam int unsigned CountLimit = (MaxEntries < 4096) ? MaxEntries : 4096;

  localparam int BlockW   = 32;
  localparam int CodeW    = 8;
  localparam int PoolLenW = 21;
  localparam int IdxW     = 12;
  localparam int StatW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 21;

  localparam logic signed [BlockW-1:0] SatMax = 32'sh7FFF_FFFF;

  localparam logic [CodeW-1:0]    DoneCodeRst    = 8'd0;
  localparam logic [CodeW-1:0]    DesiredCodeRst = 8'd1;
  localparam logic [PoolLenW-1:0] PoolLengthRst  = 21'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DONE_CODE    = 2'd0,
    CFG_DESIRED_CODE = 2'd1,
    CFG_POOL_LENGTH  = 2'd2
  } cfg_idx_e;

  typedef enum logic [StatW-1:0] {
    ST_SANE          = 3'd0,
    ST_BAD_STATUS    = 3'd1,
    ST_BAD_DONE_PAIR = 3'd2,
    ST_POOL_ORDER    = 3'd3,
    ST_DESIRED_RELOC = 3'd4,
    ST_DESIRED_END   = 3'd5
  } check_status_e;

  typedef struct packed {
    logic [CodeW-1:0]    done_code;
    logic [CodeW-1:0]    desired_code;
    logic [PoolLenW-1:0] pool_length;
  } cfg_t;

  typedef struct packed {
    logic [BlockW-1:0] pool_start;
    logic [BlockW-1:0] prev_reloc;
    logic [BlockW-1:0] device_end;
    check_status_e     sticky;
    logic [IdxW-1:0]   fail_idx;
    logic [IdxW-1:0]   count;
  } run_state_t;

  typedef struct packed {
    logic [BlockW-1:0] bad_block;
    logic [CodeW-1:0]  reloc_status;
    logic [BlockW-1:0] reloc_block;
    logic              first_entry;
    logic              last_entry;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/bbdc_check.sv =====
`default_nettype none
module bbdc_check (
  input  bbdc_pkg::cfg_t          cfg_i,
  input  bbdc_pkg::run_state_t    state_i,
  input  bbdc_pkg::entry_t        entry_i,
  output bbdc_pkg::run_state_t    state_o,
  output bbdc_pkg::check_status_e status_o,
  output logic [bbdc_pkg::IdxW-1:0] fail_idx_o
);
  import bbdc_pkg::*;

  localparam logic [IdxW:0] CountLim = (IdxW+1)'(CountLimit);

  run_state_t             cur;
  run_state_t             nxt;
  check_status_e          res;
  logic                   first_done;
  logic signed [BlockW-1:0] bb;
  logic signed [BlockW-1:0] rel;
  logic signed [BlockW-1:0] ps_cur;
  logic signed [BlockW-1:0] de_cur;
  logic signed [BlockW-1:0] lr_cur;
  logic signed [BlockW-1:0] ps;
  logic signed [BlockW-1:0] de;
  logic signed [BlockW-1:0] end_sat;
  logic [BlockW:0]          sum;

  always_comb begin
    cur    = entry_i.first_entry ? '0 : state_i;
    nxt    = cur;
    res    = ST_SANE;
    bb     = $signed(entry_i.bad_block);
    rel    = $signed(entry_i.reloc_block);
    ps_cur = $signed(cur.pool_start);
    de_cur = $signed(cur.device_end);
    lr_cur = $signed(cur.prev_reloc);
    first_done = (cur.pool_start == '0);
    // sign-extended relocation plus non-negative length, clipped at the top
    sum = {entry_i.reloc_block[BlockW-1], entry_i.reloc_block}
        + {{(BlockW+1-PoolLenW){1'b0}}, cfg_i.pool_length};
    end_sat = (sum[BlockW:BlockW-1] == 2'b01) ? SatMax : $signed(sum[BlockW-1:0]);
    ps = first_done ? rel : ps_cur;
    de = first_done ? end_sat : de_cur;

    if (cur.sticky == ST_SANE) begin
      if (entry_i.reloc_status != cfg_i.done_code &&
          entry_i.reloc_status != cfg_i.desired_code) begin
        res = ST_BAD_STATUS;
      end else if (entry_i.reloc_status == cfg_i.done_code) begin
        if (rel == '0 || bb > rel) begin
          res = ST_BAD_DONE_PAIR;
        end else begin
          nxt.pool_start = ps;
          nxt.device_end = de;
          if (rel < ps || (!first_done && rel <= lr_cur) || bb > de || rel > de) begin
            res = ST_POOL_ORDER;
          end else begin
            nxt.prev_reloc = rel;
          end
        end
      end else begin
        if (rel != '0) begin
          res = ST_DESIRED_RELOC;
        end else if (!first_done && bb > de_cur) begin
          res = ST_DESIRED_END;
        end
      end
      if (res != ST_SANE) begin
        nxt.sticky   = res;
        nxt.fail_idx = cur.count;
      end
    end

    if (({1'b0, cur.count} + 1'b1) < CountLim) begin
      nxt.count = cur.count + 1'b1;
    end

    status_o   = nxt.sticky;
    fail_idx_o = nxt.fail_idx;
    state_o    = entry_i.last_entry ? '0 : nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/bad_block_directory_checker_top.sv =====
`default_nettype none
// result path: input beat register, then result register
// throughput: one directory entry per cycle while results are taken; check is combinational
// a result waiting on the output stalls the input once the input register holds an entry
// reset: asynchronous, active low; clears running state and loads register defaults
// (done code 0, desired code 1, pool length 256)
module bad_block_directory_checker_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bbdc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [bbdc_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [bbdc_pkg::BlockW-1:0]   bad_block_i,
  input  wire logic [bbdc_pkg::CodeW-1:0]           reloc_status_i,
  input  wire logic signed [bbdc_pkg::BlockW-1:0]   reloc_block_i,
  input  wire logic                                 first_entry_i,
  input  wire logic                                 last_entry_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [bbdc_pkg::StatW-1:0]                check_status_o,
  output logic [bbdc_pkg::IdxW-1:0]                 fail_index_o,
  output logic                                      verdict_final_o
);
  import bbdc_pkg::*;

  cfg_t          cfg_q;
  run_state_t    state_q;
  run_state_t    state_d;
  entry_t        entry_q;
  logic          in_valid_q;
  logic          out_valid_q;
  check_status_e stat_d;
  logic [IdxW-1:0] idx_d;
  logic [StatW-1:0] stat_q;
  logic [IdxW-1:0]  idx_q;
  logic          final_q;
  logic          advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  bbdc_check u_check (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .entry_i    (entry_q),
    .state_o    (state_d),
    .status_o   (stat_d),
    .fail_idx_o (idx_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.done_code    <= DoneCodeRst;
      cfg_q.desired_code <= DesiredCodeRst;
      cfg_q.pool_length  <= PoolLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DONE_CODE:    cfg_q.done_code    <= cfg_data_i[CodeW-1:0];
        CFG_DESIRED_CODE: cfg_q.desired_code <= cfg_data_i[CodeW-1:0];
        CFG_POOL_LENGTH:  cfg_q.pool_length  <= cfg_data_i[PoolLenW-1:0];
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      entry_q.bad_block    <= bad_block_i;
      entry_q.reloc_status <= reloc_status_i;
      entry_q.reloc_block  <= reloc_block_i;
      entry_q.first_entry  <= first_entry_i;
      entry_q.last_entry   <= last_entry_i;
    end
  end

  // running directory state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stat_q  <= stat_d;
      idx_q   <= idx_d;
      final_q <= entry_q.last_entry;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign check_status_o  = stat_q;
  assign fail_index_o    = idx_q;
  assign verdict_final_o = final_q;

endmodule
`default_nettype wire
